// ===== rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

    localparam logic [63:0] GOLDEN_STEP  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [6:0]  FULL_PERCENT = 7'd100;
    localparam int          GRID_SHIFT   = 2;   // grid = n / 4

    // floor(x / 100) = upper 64 bits of ((x >> 2) * PCT_RECIP), then >> 2
    localparam logic [63:0] PCT_RECIP    = 64'h28F5_C28F_5C28_F5C3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PERCENT = 2'd0,
        REG_ANCHOR  = 2'd1,
        REG_BASE    = 2'd2
    } cfg_reg_t;

    // Per-item values that ride alongside the long division stages.
    typedef struct packed {
        logic [63:0] natural;
        logic [63:0] period;
        logic [63:0] grid;
        logic [63:0] target;
        logic [63:0] phase;
        logic [63:0] spread;
        logic [63:0] snap;
        logic        bypass;
        logic        pastdue;
        logic        grid0;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/pdc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pdc_item_if;
    logic        valid;
    logic        ready;
    logic [63:0] mod_time;
    logic [63:0] period_seconds;
    logic [31:0] group_id;

    modport source (output valid, output mod_time, output period_seconds,
                    output group_id, input ready);
    modport sink   (input valid, input mod_time, input period_seconds,
                    input group_id, output ready);
endinterface

interface pdc_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] trigger_time;

    modport source (output valid, output trigger_time, input ready);
    modport sink   (input valid, input trigger_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/pdc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, W pipeline stages.
module pdc_div #(
    parameter int W  = 64,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [W-1:0]  dividend,
    input  wire logic [W-1:0]  divisor,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [W-1:0]       quotient,
    output logic [W-1:0]       remainder,
    output logic [SW-1:0]      side_out
);

    logic [W-1:0]  rem_reg   [W];
    logic [W-1:0]  num_reg   [W];
    logic [W-1:0]  den_reg   [W];
    logic [SW-1:0] side_reg  [W];
    logic          valid_reg [W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [W-1:0]  num_in;
        logic [W-1:0]  den_in;
        logic [SW-1:0] sd_in;
        logic          v_in;
        logic [W:0]    trial;
        logic [W:0]    diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = dividend;
            assign den_in = divisor;
            assign sd_in  = side_in;
            assign v_in   = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign den_in = den_reg[s-1];
            assign sd_in  = side_reg[s-1];
            assign v_in   = valid_reg[s-1];
        end

        assign trial = {rem_in, num_in[W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = ~diff[W];

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_reg[s]  <= ge ? diff[W-1:0] : trial[W-1:0];
                num_reg[s]  <= {num_in[W-2:0], ge};
                den_reg[s]  <= den_in;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign quotient  = num_reg[W-1];
    assign remainder = rem_reg[W-1];
    assign side_out  = side_reg[W-1];

endmodule

`default_nettype wire

// ===== rtl/phased_deadline_calculator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Phased deadline calculator. Each item beat (mod_time, period_seconds,
// group_id) yields one trigger_time beat, in order. The datapath is a single
// pipeline that takes one beat per clock; its depth is set by one
// 64-stage bit-per-stage divider for mod_time % n (anchor % grid runs beside
// it in a second divider of the same depth) plus the hash, range-multiply,
// two-stage reciprocal scaling by 1/100 and fix-up stages around it. The
// whole pipeline advances together and holds while the output register
// carries a beat that is not taken.
// Write configuration only while no beat is in flight.
module phased_deadline_calculator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pdc_item_if.sink                             items,
    pdc_result_if.source                         results,
    input  wire logic                            cfg_we,
    input  wire logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SIDE_W = $bits(pdc_pkg::side_t);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [6:0]  percent_reg;
    logic [63:0] anchor_reg;
    logic [63:0] base_reg;
    logic [6:0]  pct_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            percent_reg <= '0;
            anchor_reg  <= '0;
            base_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdc_pkg::REG_PERCENT: percent_reg <= cfg_data[6:0];
                pdc_pkg::REG_ANCHOR:  anchor_reg  <= cfg_data;
                pdc_pkg::REG_BASE:    base_reg    <= cfg_data;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // Saturate at 100 percent.
    assign pct_eff = (percent_reg > pdc_pkg::FULL_PERCENT) ? pdc_pkg::FULL_PERCENT
                                                           : percent_reg;

    // ---------------------------------------------------------------
    // Global advance: hold everything while the output beat waits.
    // ---------------------------------------------------------------
    logic en;
    logic vF_reg;
    assign en          = ~vF_reg | results.ready;
    assign items.ready = en;

    // Stage 0: capture the input beat.
    logic        v0_reg;
    logic [63:0] mtime0_reg, n0_reg;
    logic [31:0] id0_reg;

    // Stage 1: natural time, grid, hash partial products.
    logic        v1_reg;
    logic [63:0] mtime1_reg, n1_reg, natural1_reg, grid1_reg, idlo1_reg, idhi1_reg;

    // Stage 2: seed and distance past the anchor.
    logic        v2_reg;
    logic [63:0] mtime2_reg, n2_reg, natural2_reg, grid2_reg, seed2_reg, diff2_reg;

    // Stage 3: range partial products for target, grid phase and spread.
    logic        v3_reg;
    logic [63:0] mtime3_reg, n3_reg, natural3_reg, grid3_reg;
    logic [63:0] ll3_reg [3];
    logic [63:0] lh3_reg [3];
    logic [63:0] hl3_reg [3];
    logic [63:0] hh3_reg [3];

    // Stage 4: range results and path flags.
    logic            v4_reg;
    logic [63:0]     mtime4_reg;
    pdc_pkg::side_t  side4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= items.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    logic [63:0] rng_m [3];
    logic [63:0] rng_hi [3];
    logic [33:0] rng_mid [3];

    assign rng_m[0] = n2_reg;
    assign rng_m[1] = grid2_reg;
    assign rng_m[2] = diff2_reg;

    // Upper half of the 128-bit product from four 32x32 partials.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            rng_mid[l] = {2'b00, ll3_reg[l][63:32]} + {2'b00, lh3_reg[l][31:0]}
                       + {2'b00, hl3_reg[l][31:0]};
            rng_hi[l]  = hh3_reg[l] + {32'd0, lh3_reg[l][63:32]}
                       + {32'd0, hl3_reg[l][63:32]} + {62'd0, rng_mid[l][33:32]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mtime0_reg <= items.mod_time;
            n0_reg     <= items.period_seconds;
            id0_reg    <= items.group_id;

            mtime1_reg   <= mtime0_reg;
            n1_reg       <= n0_reg;
            natural1_reg <= mtime0_reg + n0_reg;
            grid1_reg    <= n0_reg >> pdc_pkg::GRID_SHIFT;
            idlo1_reg    <= 64'(id0_reg) * 64'(pdc_pkg::GOLDEN_STEP[31:0]);
            idhi1_reg    <= 64'(id0_reg) * 64'(pdc_pkg::GOLDEN_STEP[63:32]);

            mtime2_reg   <= mtime1_reg;
            n2_reg       <= n1_reg;
            natural2_reg <= natural1_reg;
            grid2_reg    <= grid1_reg;
            seed2_reg    <= base_reg + idlo1_reg + {idhi1_reg[31:0], 32'd0};
            diff2_reg    <= natural1_reg - anchor_reg;

            mtime3_reg   <= mtime2_reg;
            n3_reg       <= n2_reg;
            natural3_reg <= natural2_reg;
            grid3_reg    <= grid2_reg;
            for (int l = 0; l < 3; l++)
            begin
                ll3_reg[l] <= 64'(seed2_reg[31:0])  * 64'(rng_m[l][31:0]);
                lh3_reg[l] <= 64'(seed2_reg[31:0])  * 64'(rng_m[l][63:32]);
                hl3_reg[l] <= 64'(seed2_reg[63:32]) * 64'(rng_m[l][31:0]);
                hh3_reg[l] <= 64'(seed2_reg[63:32]) * 64'(rng_m[l][63:32]);
            end

            mtime4_reg        <= mtime3_reg;
            side4_reg.natural <= natural3_reg;
            side4_reg.period  <= n3_reg;
            side4_reg.grid    <= grid3_reg;
            side4_reg.target  <= rng_hi[0];
            side4_reg.phase   <= rng_hi[1];
            side4_reg.spread  <= rng_hi[2];
            side4_reg.snap    <= '0;
            side4_reg.bypass  <= (percent_reg == '0) || (n3_reg == '0);
            side4_reg.pastdue <= natural3_reg <= anchor_reg;
            side4_reg.grid0   <= grid3_reg == '0;
        end
    end

    // ---------------------------------------------------------------
    // mod_time % n and anchor % grid, side by side.
    // ---------------------------------------------------------------
    logic            vD_reg_a;
    logic [63:0]     mrem_d;
    logic [63:0]     arem_d;
    logic [SIDE_W-1:0] side_d_bits;
    pdc_pkg::side_t  side_d;

    pdc_div #(.W(64), .SW(SIDE_W)) u_div_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .dividend  (mtime4_reg),
        .divisor   (side4_reg.period),
        .side_in   (side4_reg),
        .out_valid (vD_reg_a),
        .quotient  (),
        .remainder (mrem_d),
        .side_out  (side_d_bits)
    );

    pdc_div #(.W(64), .SW(1)) u_div_grid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .dividend  (anchor_reg),
        .divisor   (side4_reg.grid),
        .side_in   (1'b0),
        .out_valid (),
        .quotient  (),
        .remainder (arem_d),
        .side_out  ()
    );

    assign side_d = pdc_pkg::side_t'(side_d_bits);

    // Stage A: raw phase gap and raw grid step.
    logic           vA_reg;
    pdc_pkg::side_t sideA_reg;
    logic [64:0]    gapA_reg;
    logic [63:0]    stepA_reg;

    // Stage B: reduced gap (offset) and reduced grid step.
    logic           vB_reg;
    pdc_pkg::side_t sideB_reg;
    pdc_pkg::side_t sideB_next;
    logic [63:0]    offB_reg;

    // Stage C: offset * percent, absolute snap and spread times.
    logic           vC_reg;
    pdc_pkg::side_t sideC_reg;
    pdc_pkg::side_t sideC_next;
    logic [63:0]    prodC_reg;
    logic [70:0]    prod_full;

    // Stage P: partial products of (offset * percent) / 4 with the reciprocal.
    logic           vP_reg;
    pdc_pkg::side_t sideP_reg;
    logic [63:0]    pll_reg, plh_reg, phl_reg, phh_reg;

    // Stage Q: pull = upper half of the reciprocal product, shifted by 2.
    logic           vQ_reg;
    pdc_pkg::side_t sideQ_reg;
    logic [63:0]    pullQ_reg;
    logic [33:0]    pull_mid;
    logic [63:0]    pull_hi;

    assign prod_full = 71'(offB_reg) * 71'(pct_eff);

    always_comb
    begin
        sideB_next      = sideA_reg;
        sideB_next.snap = (stepA_reg >= sideA_reg.grid) ? stepA_reg - sideA_reg.grid
                                                        : stepA_reg;

        sideC_next        = sideB_reg;
        sideC_next.snap   = anchor_reg + sideB_reg.snap;
        sideC_next.spread = anchor_reg + sideB_reg.spread;

        pull_mid = {2'b00, pll_reg[63:32]} + {2'b00, plh_reg[31:0]}
                 + {2'b00, phl_reg[31:0]};
        pull_hi  = phh_reg + {32'd0, plh_reg[63:32]} + {32'd0, phl_reg[63:32]}
                 + {62'd0, pull_mid[33:32]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vA_reg <= 1'b0;
            vB_reg <= 1'b0;
            vC_reg <= 1'b0;
            vP_reg <= 1'b0;
            vQ_reg <= 1'b0;
        end
        else if (en)
        begin
            vA_reg <= vD_reg_a;
            vB_reg <= vA_reg;
            vC_reg <= vB_reg;
            vP_reg <= vC_reg;
            vQ_reg <= vP_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sideA_reg <= side_d;
            gapA_reg  <= {1'b0, mrem_d} + {1'b0, side_d.period} - {1'b0, side_d.target};
            stepA_reg <= side_d.phase + side_d.grid - arem_d;

            sideB_reg <= sideB_next;
            // A gap past 2^64 wraps to a value already below n.
            if (gapA_reg[64])
            begin
                offB_reg <= gapA_reg[63:0];
            end
            else if (gapA_reg[63:0] >= sideA_reg.period)
            begin
                offB_reg <= gapA_reg[63:0] - sideA_reg.period;
            end
            else
            begin
                offB_reg <= gapA_reg[63:0];
            end

            sideC_reg <= sideC_next;
            prodC_reg <= prod_full[63:0];

            // Divide by 100: pre-shift by 2, multiply by the reciprocal.
            sideP_reg <= sideC_reg;
            pll_reg   <= 64'(prodC_reg[33:2])  * 64'(pdc_pkg::PCT_RECIP[31:0]);
            plh_reg   <= 64'(prodC_reg[33:2])  * 64'(pdc_pkg::PCT_RECIP[63:32]);
            phl_reg   <= 64'(prodC_reg[63:34]) * 64'(pdc_pkg::PCT_RECIP[31:0]);
            phh_reg   <= 64'(prodC_reg[63:34]) * 64'(pdc_pkg::PCT_RECIP[63:32]);

            sideQ_reg <= sideP_reg;
            pullQ_reg <= {2'b00, pull_hi[63:2]};
        end
    end

    // Stage E: pulled trigger. Stage F: path select into the output register.
    logic           vE_reg;
    pdc_pkg::side_t sideE_reg;
    logic [63:0]    pulledE_reg;
    logic [63:0]    trigF_reg;
    logic [63:0]    trig_next;

    always_comb
    begin
        if (sideE_reg.bypass)
        begin
            trig_next = sideE_reg.natural;
        end
        else if (sideE_reg.pastdue)
        begin
            trig_next = sideE_reg.grid0 ? anchor_reg : sideE_reg.snap;
        end
        else if (pulledE_reg >= anchor_reg)
        begin
            trig_next = pulledE_reg;
        end
        else
        begin
            trig_next = sideE_reg.spread;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vE_reg <= 1'b0;
            vF_reg <= 1'b0;
        end
        else if (en)
        begin
            vE_reg <= vQ_reg;
            vF_reg <= vE_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sideE_reg   <= sideQ_reg;
            pulledE_reg <= sideQ_reg.natural - pullQ_reg;
            trigF_reg   <= trig_next;
        end
    end

    assign results.valid        = vF_reg;
    assign results.trigger_time = trigF_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !items.ready |-> results.valid)
        else $error("input stalled with an empty output register");

    a_bypass_natural: assert property (@(posedge clk) disable iff (!rst_n)
        en && vE_reg && sideE_reg.bypass |=>
            results.valid && results.trigger_time == $past(sideE_reg.natural))
        else $error("phasing-off beat lost its natural trigger");

    a_not_before_anchor: assert property (@(posedge clk) disable iff (!rst_n)
        en && vE_reg && !sideE_reg.bypass && !sideE_reg.pastdue |=>
            results.trigger_time >= anchor_reg)
        else $error("phased trigger landed before the anchor");

endmodule

`default_nettype wire

// ===== tb/pdc_trigger_checker.sv =====
`timescale 1ns / 1ps

module pdc_trigger_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pdc_item_if.sink         items,
    pdc_result_if.sink       results,
    input  wire logic        cfg_we,
    input  wire logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int               fail_count,
    output int               pending_count,
    output int               checked_count
);

    logic [6:0]  shadow_percent;
    logic [63:0] shadow_anchor;
    logic [63:0] shadow_base;
    logic [63:0] expected_triggers[$];

    function automatic logic [63:0] upper_product(logic [63:0] a, logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, m};
        return p[127:64];
    endfunction

    function automatic logic [63:0] predict_trigger(logic [63:0] mtime, logic [63:0] n,
                                                    logic [31:0] id);
        logic [63:0] natural, pct, seed, target, offset, pull, pulled, grid, phase;
        natural = mtime + n;
        pct = (shadow_percent > pdc_pkg::FULL_PERCENT) ? 64'(pdc_pkg::FULL_PERCENT)
                                                       : 64'(shadow_percent);
        if (pct == 0 || n == 0)
            return natural;
        seed   = shadow_base + {32'd0, id} * pdc_pkg::GOLDEN_STEP;
        target = upper_product(seed, n);
        offset = ((mtime % n) + n - target) % n;
        pull   = (offset * pct) / 64'd100;
        pulled = natural - pull;
        if (natural <= shadow_anchor)
        begin
            grid = n >> pdc_pkg::GRID_SHIFT;
            if (grid == 0)
                return shadow_anchor;
            phase = upper_product(seed, grid);
            return shadow_anchor + (phase + grid - shadow_anchor % grid) % grid;
        end
        if (pulled >= shadow_anchor)
            return pulled;
        return shadow_anchor + upper_product(seed, natural - shadow_anchor);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_percent <= '0;
            shadow_anchor  <= '0;
            shadow_base    <= '0;
            expected_triggers.delete();
            fail_count    = 0;
            checked_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (items.valid && items.ready)
                expected_triggers.push_back(predict_trigger(items.mod_time,
                    items.period_seconds, items.group_id));
            if (results.valid && results.ready)
            begin
                checked_count++;
                if (expected_triggers.size() == 0)
                    report_mismatch("unexpected beat", results.trigger_time, 64'd0);
                else if (results.trigger_time !== expected_triggers[0])
                    report_mismatch("trigger_time", results.trigger_time,
                                    expected_triggers.pop_front());
                else
                    void'(expected_triggers.pop_front());
            end
            pending_count = expected_triggers.size();
            if (cfg_we)
            begin
                case (cfg_index)
                    pdc_pkg::REG_PERCENT: shadow_percent <= cfg_data[6:0];
                    pdc_pkg::REG_ANCHOR:  shadow_anchor  <= cfg_data;
                    pdc_pkg::REG_BASE:    shadow_base    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/phased_deadline_calculator_test.sv =====
`timescale 1ns / 1ps

module phased_deadline_calculator_test;

    localparam int LATENCY     = 75;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data;
    int fail_count, pending_count, checked_count;
    int cycle_count;
    int sent_count;
    bit hold_off_request;

    pdc_item_if   item_ch();
    pdc_result_if result_ch();

    phased_deadline_calculator i_dut (
        .clk(clk), .rst_n(rst_n), .items(item_ch.sink), .results(result_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pdc_trigger_checker i_checker (
        .clk(clk), .rst_n(rst_n), .items(item_ch.sink), .results(result_ch.sink),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .checked_count(checked_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: count cycles and give up at a generous limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Draw a gap length: mostly zero or short, now and then long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random ready with short and long stalls, plus one long hold-off
    // on request so the pipeline backs up into the input.
    initial
    begin
        int stall;
        int hold;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                result_ch.ready = 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
            end
            stall = draw_gap();
            if (stall == 0 || $urandom_range(0, 3) == 0)
                result_ch.ready = 1'b1;
            else
            begin
                result_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // Drive one item beat and wait for the handshake; valid stays low after.
    task automatic send_item(logic [63:0] mtime, logic [63:0] n, logic [31:0] id);
        item_ch.valid          = 1'b1;
        item_ch.mod_time       = mtime;
        item_ch.period_seconds = n;
        item_ch.group_id       = id;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
        item_ch.valid = 1'b0;
        sent_count++;
    endtask

    task automatic send_with_gap(logic [63:0] mtime, logic [63:0] n, logic [31:0] id);
        int gap;
        gap = draw_gap();
        repeat (gap) @(negedge clk);
        send_item(mtime, n, id);
    endtask

    task automatic write_reg(pdc_pkg::cfg_reg_t idx, logic [63:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Let the pipeline drain before touching registers.
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Period: mostly small, some tiny (grid zero or one), a few full width.
    function automatic logic [63:0] rand_period();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 64'($urandom_range(0, 7));
        if (r < 7)
            return 64'($urandom_range(1, 200000));
        return rand64();
    endfunction

    // Modification time mostly placed around the anchor so every branch is hit.
    function automatic logic [63:0] rand_mtime(logic [63:0] anchor, logic [63:0] n);
        case ($urandom_range(0, 4))
            0: return anchor - n - 64'($urandom_range(0, 1000));
            1: return anchor - n + 64'($urandom_range(0, 1000));
            2: return anchor - 64'($urandom_range(0, 100000));
            3: return anchor + 64'($urandom_range(0, 100000));
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        logic [63:0] anchor;
        logic [6:0]  percents[6];
        logic [63:0] anchors[6];
        int phase_idx;
        int k;
        percents = '{7'd0, 7'd100, 7'd37, 7'd127, 7'd1, 7'd101};
        anchors  = '{64'd0, 64'd1_700_000_000, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'd50_000, 64'h8000_0000_0000_0000, 64'd1_000_000};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pdc_pkg::REG_PERCENT;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.mod_time = '0;
        item_ch.period_seconds = '0;
        item_ch.group_id = '0;
        cycle_count = 0;
        sent_count = 0;
        hold_off_request = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings (phasing off), then extremes with phasing on.
        send_item(64'd0, 64'd0, 32'd0);
        send_item('1, '1, '1);
        send_item(64'd1000, 64'd86400, 32'd5);
        drain();
        write_reg(pdc_pkg::REG_PERCENT, 64'd100);
        write_reg(pdc_pkg::REG_ANCHOR, 64'd1_000_000);
        write_reg(pdc_pkg::REG_BASE, 64'h0123_4567_89AB_CDEF);
        cfg_index = pdc_pkg::cfg_reg_t'(2'd3);   // unused index: write must be ignored
        cfg_we = 1'b1;
        cfg_data = '1;
        @(negedge clk);
        cfg_we = 1'b0;
        send_item(64'd5, 64'd0, 32'd1);              // zero period
        send_item(64'd10, 64'd100, 32'd2);           // past due, grid 25
        send_item(64'd10, 64'd3, 32'd3);             // past due, grid zero
        send_item(64'd999_900, 64'd100, 32'd4);      // natural equals anchor
        send_item(64'd1_000_000, 64'd86400, 32'd7);  // pull fits
        send_item(64'd950_000, 64'd86400, 32'd9);    // pull before anchor
        send_item('1, 64'd1, '1);                    // wrap of natural
        send_item('1, '1, 32'd0);
        send_item(64'd0, '1, 32'h8000_0000);
        send_item(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 32'd12345);
        drain();

        // Random phases across register settings, extremes included.
        for (phase_idx = 0; phase_idx < 6; phase_idx++)
        begin
            anchor = anchors[phase_idx];
            write_reg(pdc_pkg::REG_PERCENT, {57'd0, percents[phase_idx]});
            write_reg(pdc_pkg::REG_ANCHOR, anchor);
            write_reg(pdc_pkg::REG_BASE, (phase_idx == 2) ? '1 : rand64());
            for (k = 0; k < 265; k++)
            begin
                logic [63:0] n;
                if (phase_idx == 1 && k == 40)
                    hold_off_request = 1'b1;
                n = rand_period();
                if (k % 3 == 0)
                    send_item(rand_mtime(anchor, n), n, $urandom());
                else
                    send_with_gap(rand_mtime(anchor, n), n, $urandom());
            end
            drain();
        end

        $display("sent %0d item beats over 6 register settings, checked %0d results",
                 sent_count, checked_count);
        $display("covered phasing off, past-due grid, pull fit, pull before anchor, wrap");
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
